// ===== rtl/core/dns_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dns_pkg
// Shared types and constants of the decimal number scanner.
// ----------------------------------------------------------------------------
package dns_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [4:0]  SIG_LIMIT = 5'd19;
  localparam logic [30:0] HUGE_EXP  = 31'd1000000000;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_INT  = 2'd1;
  localparam logic [1:0] ST_NO_FRAC = 2'd2;
  localparam logic [1:0] ST_NO_EXP  = 2'd3;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [63:0]        magnitude;
    logic               is_negative;
    logic signed [31:0] decimal_exponent;
    logic               needs_float;
    logic [1:0]         status;
  } out_item_t;

  typedef enum logic [2:0] {
    CL_DIGIT,
    CL_MINUS,
    CL_PLUS,
    CL_DOT,
    CL_EXP,
    CL_SPACE,
    CL_OTHER
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [3:0] digit;
    logic       last;
  } qent_t;

endpackage
`default_nettype wire

// ===== rtl/core/decimal_number_scanner.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_number_scanner
// Scans decimal numbers from a text byte stream, one byte per transfer.
// Throughput: one byte per cycle while the queue has room and the output is not
//   stalled; a number closed by end_of_text also passes a finish state in the back end.
// Result path: the terminating byte goes through the queue and then the back
//   end's result register; a number closed by end_of_text also passes the finish state.
// Reset: synchronous; empties the queue, returns to idle, digit limit 19.
// ----------------------------------------------------------------------------
module decimal_number_scanner #(
  parameter int QUEUE_DEPTH = dns_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [4:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire dns_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output dns_pkg::out_item_t      out_data
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_valid;
  dns_pkg::qent_t q_wdata;
  dns_pkg::qent_t q_rdata;

  dns_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  dns_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  dns_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/core/dns_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dns_front
// Classifies each incoming text byte and hands it to the queue.
// ----------------------------------------------------------------------------
module dns_front (
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire dns_pkg::in_item_t in_data,
  input  wire logic              q_full,
  output logic                   q_push,
  output dns_pkg::qent_t         q_wdata
);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_LOW_E = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  logic [7:0] offs;

  assign offs     = in_data.text_byte - CH_ZERO;
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_wdata.digit = offs[3:0];
    q_wdata.last  = in_data.end_of_text;
    if (offs < 8'd10) begin
      q_wdata.cls = dns_pkg::CL_DIGIT;
    end else if (in_data.text_byte == CH_MINUS) begin
      q_wdata.cls = dns_pkg::CL_MINUS;
    end else if (in_data.text_byte == CH_PLUS) begin
      q_wdata.cls = dns_pkg::CL_PLUS;
    end else if (in_data.text_byte == CH_DOT) begin
      q_wdata.cls = dns_pkg::CL_DOT;
    end else if (in_data.text_byte == CH_LOW_E || in_data.text_byte == CH_UP_E) begin
      q_wdata.cls = dns_pkg::CL_EXP;
    end else if (in_data.text_byte inside {CH_SPACE, CH_LF, CH_CR, CH_NUL}) begin
      q_wdata.cls = dns_pkg::CL_SPACE;
    end else begin
      q_wdata.cls = dns_pkg::CL_OTHER;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/dns_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dns_queue
// Small FIFO of classified bytes between front and back.
// ----------------------------------------------------------------------------
module dns_queue #(
  parameter int DEPTH = dns_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire dns_pkg::qent_t  wdata,
  output logic                 full,
  input  wire logic            pop,
  output logic                 valid,
  output dns_pkg::qent_t       rdata
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

  dns_pkg::qent_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == DEPTH_C);
  assign valid = (count != '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst) count <= DEPTH_C)
    else $error("queue count above depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> valid)
    else $error("pop from empty queue");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on push");

endmodule
`default_nettype wire

// ===== rtl/core/dns_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dns_back
// Number scanning state machine, accumulators and result register.
// ----------------------------------------------------------------------------
module dns_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [4:0]        cfg_data,
  input  wire logic              q_valid,
  input  wire dns_pkg::qent_t    q_rdata,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output dns_pkg::out_item_t     out_data
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_AFTER_MINUS,
    PH_INT,
    PH_AFTER_ZERO,
    PH_AFTER_POINT,
    PH_FRAC,
    PH_AFTER_E,
    PH_AFTER_ESIGN,
    PH_EXP,
    PH_FINISH
  } phase_t;

  localparam logic signed [33:0] EACC_MAX = {1'b0, {33{1'b1}}};
  localparam logic signed [33:0] EACC_MIN = {1'b1, {33{1'b0}}};
  localparam logic [34:0] EDIG_MAX = {4'd0, {31{1'b1}}};
  localparam logic signed [34:0] E32_MAX = {3'b000, 1'b0, {31{1'b1}}};
  localparam logic signed [34:0] E32_MIN = {3'b111, 1'b1, {31{1'b0}}};

  phase_t             phase, phase_next;
  logic [4:0]         limit;
  logic [63:0]        mant, mant_next;
  logic [4:0]         dcount, dcount_next;
  logic signed [33:0] eacc, eacc_next;
  logic [30:0]        edig, edig_next;
  logic               eneg, eneg_next;
  logic               sign, sign_next;
  logic               flt, flt_next;

  logic               go;
  logic               emit_ok;
  logic               emit_err;
  logic [1:0]         err_code;
  logic               dig;
  logic [63:0]        mant_x10;
  logic [34:0]        edig_x10;
  logic [4:0]         dcount_inc;
  logic signed [33:0] eacc_inc;
  logic signed [33:0] eacc_dec;
  logic signed [34:0] e_sum;
  logic signed [31:0] e_sat;
  logic               mant_kill;

  assign go  = !out_valid || !out_stall;
  assign q_pop = q_valid && go && (phase != PH_FINISH);
  assign dig = (q_rdata.cls == dns_pkg::CL_DIGIT);

  assign mant_x10   = (mant << 3) + (mant << 1) + {60'd0, q_rdata.digit};
  assign edig_x10   = ({4'd0, edig} << 3) + ({4'd0, edig} << 1) + {31'd0, q_rdata.digit};
  assign dcount_inc = (dcount == 5'd31) ? dcount : dcount + 5'd1;
  assign eacc_inc   = (eacc == EACC_MAX) ? eacc : eacc + 34'sd1;
  assign eacc_dec   = (eacc == EACC_MIN) ? eacc : eacc - 34'sd1;

  assign e_sum = {eacc[33], eacc} + (eneg ? -$signed({4'd0, edig}) : $signed({4'd0, edig}));
  assign e_sat = (e_sum > E32_MAX) ? E32_MAX[31:0] :
                 (e_sum < E32_MIN) ? E32_MIN[31:0] : e_sum[31:0];
  assign mant_kill = eneg && (edig > dns_pkg::HUGE_EXP);

  always_comb begin
    phase_next  = phase;
    mant_next   = mant;
    dcount_next = dcount;
    eacc_next   = eacc;
    edig_next   = edig;
    eneg_next   = eneg;
    sign_next   = sign;
    flt_next    = flt;
    emit_ok     = 1'b0;
    emit_err    = 1'b0;
    err_code    = dns_pkg::ST_OK;

    if (phase == PH_FINISH && go) begin
      emit_ok = 1'b1;
    end

    if (q_pop) begin
      case (phase)
        PH_IDLE: begin
          if (q_rdata.cls != dns_pkg::CL_SPACE) begin
            mant_next   = '0;
            dcount_next = '0;
            eacc_next   = '0;
            edig_next   = '0;
            eneg_next   = 1'b0;
            sign_next   = 1'b0;
            flt_next    = 1'b0;
            if (q_rdata.cls == dns_pkg::CL_MINUS) begin
              sign_next  = 1'b1;
              phase_next = PH_AFTER_MINUS;
            end else if (dig) begin
              mant_next   = {60'd0, q_rdata.digit};
              dcount_next = (q_rdata.digit != 4'd0) ? 5'd1 : 5'd0;
              phase_next  = (q_rdata.digit != 4'd0) ? PH_INT : PH_AFTER_ZERO;
            end else begin
              emit_err = 1'b1;
              err_code = dns_pkg::ST_NO_INT;
            end
          end
        end
        PH_AFTER_MINUS: begin
          if (dig) begin
            mant_next   = {60'd0, q_rdata.digit};
            dcount_next = (q_rdata.digit != 4'd0) ? 5'd1 : 5'd0;
            phase_next  = (q_rdata.digit != 4'd0) ? PH_INT : PH_AFTER_ZERO;
          end else begin
            emit_err = 1'b1;
            err_code = dns_pkg::ST_NO_INT;
          end
        end
        PH_INT, PH_AFTER_ZERO: begin
          if (dig && phase == PH_INT) begin
            if (dcount < limit) begin
              mant_next = mant_x10;
            end else begin
              eacc_next = eacc_inc;
            end
            dcount_next = dcount_inc;
          end else if (q_rdata.cls == dns_pkg::CL_DOT) begin
            flt_next   = 1'b1;
            phase_next = PH_AFTER_POINT;
          end else if (q_rdata.cls == dns_pkg::CL_EXP) begin
            flt_next   = 1'b1;
            phase_next = PH_AFTER_E;
          end else begin
            emit_ok = 1'b1;
          end
        end
        PH_AFTER_POINT, PH_FRAC: begin
          if (dig) begin
            if (dcount < limit) begin
              mant_next = mant_x10;
              eacc_next = eacc_dec;
              if (mant != '0 || q_rdata.digit != 4'd0) begin
                dcount_next = dcount_inc;
              end
            end
            phase_next = PH_FRAC;
          end else if (phase == PH_AFTER_POINT) begin
            emit_err = 1'b1;
            err_code = dns_pkg::ST_NO_FRAC;
          end else if (q_rdata.cls == dns_pkg::CL_EXP) begin
            phase_next = PH_AFTER_E;
          end else begin
            emit_ok = 1'b1;
          end
        end
        PH_AFTER_E, PH_AFTER_ESIGN, PH_EXP: begin
          if (dig) begin
            edig_next  = (edig_x10 > EDIG_MAX) ? EDIG_MAX[30:0] : edig_x10[30:0];
            phase_next = PH_EXP;
          end else if (phase == PH_AFTER_E && q_rdata.cls == dns_pkg::CL_MINUS) begin
            eneg_next  = 1'b1;
            phase_next = PH_AFTER_ESIGN;
          end else if (phase == PH_AFTER_E && q_rdata.cls == dns_pkg::CL_PLUS) begin
            phase_next = PH_AFTER_ESIGN;
          end else if (phase == PH_EXP) begin
            emit_ok = 1'b1;
          end else begin
            emit_err = 1'b1;
            err_code = dns_pkg::ST_NO_EXP;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase

      if (q_rdata.last && !emit_ok && !emit_err) begin
        if (phase_next inside {PH_INT, PH_AFTER_ZERO, PH_FRAC, PH_EXP}) begin
          phase_next = PH_FINISH;
        end else if (phase_next == PH_AFTER_MINUS) begin
          emit_err = 1'b1;
          err_code = dns_pkg::ST_NO_INT;
        end else if (phase_next == PH_AFTER_POINT) begin
          emit_err = 1'b1;
          err_code = dns_pkg::ST_NO_FRAC;
        end else if (phase_next inside {PH_AFTER_E, PH_AFTER_ESIGN}) begin
          emit_err = 1'b1;
          err_code = dns_pkg::ST_NO_EXP;
        end
      end
    end

    if (emit_ok || emit_err) begin
      phase_next = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      limit     <= dns_pkg::SIG_LIMIT;
      mant      <= '0;
      dcount    <= '0;
      eacc      <= '0;
      edig      <= '0;
      eneg      <= 1'b0;
      sign      <= 1'b0;
      flt       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      phase  <= phase_next;
      mant   <= mant_next;
      dcount <= dcount_next;
      eacc   <= eacc_next;
      edig   <= edig_next;
      eneg   <= eneg_next;
      sign   <= sign_next;
      flt    <= flt_next;
      if (cfg_we) begin
        limit <= (cfg_data > dns_pkg::SIG_LIMIT) ? dns_pkg::SIG_LIMIT : cfg_data;
      end
      if (emit_ok || emit_err) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (emit_ok) begin
      out_data.magnitude        <= mant_kill ? '0 : mant;
      out_data.is_negative      <= sign;
      out_data.decimal_exponent <= e_sat;
      out_data.needs_float      <= flt;
      out_data.status           <= dns_pkg::ST_OK;
    end else if (emit_err) begin
      out_data.magnitude        <= '0;
      out_data.is_negative      <= 1'b0;
      out_data.decimal_exponent <= '0;
      out_data.needs_float      <= 1'b0;
      out_data.status           <= err_code;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (emit_ok || emit_err) |-> go)
    else $error("result produced while output register busy");
  a_finish_no_pop: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_FINISH) |-> !q_pop)
    else $error("byte consumed while finishing a number");
  a_emit_to_idle: assert property (@(posedge clk) disable iff (rst)
    (emit_ok || emit_err) |=> phase == PH_IDLE && out_valid)
    else $error("scanner not idle after result");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != dns_pkg::ST_OK) |-> out_data.magnitude == '0)
    else $error("error result carries a magnitude");

endmodule
`default_nettype wire
